>>> rtl/core/dmaf_pkg.sv
// Shared constants for the decimating moving-average filter.
`timescale 1ns / 1ps

package dmaf_pkg;

    localparam int OUT_BITS        = 12;
    localparam int DEF_DECIMATION  = 16;
    localparam int DEF_AVG_DEPTH   = 8;
    localparam int DEF_SAMPLE_BITS = 12;

endpackage

>>> rtl/core/dmaf_if.sv
// Valid/ready stream interfaces for samples in and filter results out.
`timescale 1ns / 1ps

interface dmaf_smp_if #(
    parameter int SAMPLE_BITS = dmaf_pkg::DEF_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface dmaf_res_if;
    import dmaf_pkg::*;

    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] decimated;
    logic [OUT_BITS-1:0] filtered;

    modport source (output valid, output decimated, output filtered, input ready);
    modport sink   (input valid, input decimated, input filtered, output ready);
endinterface

>>> rtl/core/dmaf_cell.sv
// One entry of the history shift line: loads its neighbor's value on a shift.
`timescale 1ns / 1ps

module dmaf_cell #(
    parameter int W = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_shift,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

>>> rtl/core/dmaf_recip.sv
// Divide by a constant: registered multiply by a rounded-up reciprocal, exact for XW-bit inputs.
`timescale 1ns / 1ps

module dmaf_recip #(
    parameter int DIVISOR = 16,
    parameter int XW      = 16,
    parameter int QW      = 12
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [XW-1:0] i_x,
    output logic [QW-1:0] o_q
);

    localparam int L  = $clog2(DIVISOR);
    localparam int S  = XW + L;
    localparam int MW = XW + 1;
    localparam int PW = XW + MW;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << S) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_FULL);

    logic [PW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PW'(i_x) * PW'(RECIP);
        end
    end

    // quotient is the product scaled down by 2^S
    assign o_q = r_prod[S +: QW];

endmodule

>>> rtl/core/decimating_average_moving_filter.sv
// Top level: block accumulator, constant dividers and the history cell chain.
//
//   port    | dir | handshake     | payload
//   i_smp   | in  | valid / ready | sample [SAMPLE_BITS-1:0]
//   o_res   | out | valid / ready | decimated [11:0], filtered [11:0]
//
// One sample is taken per cycle while i_smp.ready is high; every DECIMATION-th sample
// yields one result through accumulate, reciprocal multiply, ring update and reciprocal multiply.
// The history ring is a chain of AVG_DEPTH cells shifted once per block, with a running total.
// Synchronous active-low reset clears the accumulator, counter, cells, total and valids.
// A stalled result holds in the output register; samples keep flowing unless every
// stage behind it is full, and then i_smp.ready drops.
`timescale 1ns / 1ps

module decimating_average_moving_filter #(
    parameter int DECIMATION  = dmaf_pkg::DEF_DECIMATION,
    parameter int AVG_DEPTH   = dmaf_pkg::DEF_AVG_DEPTH,
    parameter int SAMPLE_BITS = dmaf_pkg::DEF_SAMPLE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dmaf_smp_if.sink   i_smp,
    dmaf_res_if.source o_res
);
    import dmaf_pkg::*;

    localparam int CW = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam int AW = SAMPLE_BITS + $clog2(DECIMATION);
    localparam int TW = SAMPLE_BITS + $clog2(AVG_DEPTH);

    // block accumulator
    logic [AW-1:0] r_acc;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] blk_sum;
    logic          blk_last;
    logic          smp_fire;

    // pipeline stages
    logic                   r_v1, r_v2, r_v3, r_v4;
    logic                   adv1, adv2, adv3, adv4;
    logic [AW-1:0]          r_sum1;
    logic [SAMPLE_BITS-1:0] dec;
    logic [SAMPLE_BITS-1:0] r_dec3, r_dec4;
    logic [TW-1:0]          r_total, n_total, r_tot3;
    logic [SAMPLE_BITS-1:0] filt;
    logic                   ring_shift;

    logic [SAMPLE_BITS-1:0] cell_q [AVG_DEPTH];

    assign adv4 = !r_v4 || o_res.ready;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign i_smp.ready = adv1;
    assign smp_fire    = i_smp.valid && adv1;
    assign blk_sum     = r_acc + AW'(i_smp.sample);
    assign blk_last    = (r_cnt == CW'(DECIMATION - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else if (smp_fire) begin
            if (blk_last) begin
                r_acc <= '0;
                r_cnt <= '0;
            end else begin
                r_acc <= blk_sum;
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= smp_fire && blk_last;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) r_sum1 <= blk_sum;
        if (adv3) begin
            r_dec3 <= dec;
            r_tot3 <= n_total;
        end
        if (adv4) r_dec4 <= r_dec3;
    end

    dmaf_recip #(
        .DIVISOR (DECIMATION),
        .XW      (AW),
        .QW      (SAMPLE_BITS)
    ) u_dec_div (
        .i_clk (i_clk),
        .i_en  (adv2),
        .i_x   (r_sum1),
        .o_q   (dec)
    );

    // push the new block mean in, drop the oldest off the far end
    assign ring_shift = r_v2 && adv3;
    assign n_total    = r_total - TW'(cell_q[AVG_DEPTH-1]) + TW'(dec);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (ring_shift) begin
            r_total <= n_total;
        end
    end

    for (genvar k = 0; k < AVG_DEPTH; k++) begin : g_cell
        dmaf_cell #(
            .W (SAMPLE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (ring_shift),
            .i_d     ((k == 0) ? dec : cell_q[(k == 0) ? 0 : k - 1]),
            .o_q     (cell_q[k])
        );
    end

    dmaf_recip #(
        .DIVISOR (AVG_DEPTH),
        .XW      (TW),
        .QW      (SAMPLE_BITS)
    ) u_filt_div (
        .i_clk (i_clk),
        .i_en  (adv4),
        .i_x   (r_tot3),
        .o_q   (filt)
    );

    assign o_res.valid     = r_v4;
    assign o_res.decimated = OUT_BITS'(r_dec4);
    assign o_res.filtered  = OUT_BITS'(filt);

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DECIMATION - 1))
        else $error("sample counter past block length");

    a_blk_to_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && smp_fire && blk_last |=> r_v1)
        else $error("completed block did not enter the divider stage");

    a_acc_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && smp_fire && !blk_last |=>
            r_acc == $past(r_acc) + AW'($past(i_smp.sample)))
        else $error("accumulator missed a sample");

    a_total_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !ring_shift |=> $stable(r_total))
        else $error("ring total moved without a ring update");
`endif

endmodule
